@@ hdl/assert_macros.svh @@
// Assertion macros shared by the pooling block.
// No dependencies; take in with a plain include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock, masked while in reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/ppool_pkg.sv @@
// Types and codes shared by the pooling block.
// No dependencies.
package ppool_pkg;

   // Pooling modes; code three behaves as minimum
   localparam logic [1:0] MODE_AVG = 2'd0;
   localparam logic [1:0] MODE_MAX = 2'd1;
   localparam logic [1:0] MODE_MIN = 2'd2;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_POOL_MODE   = 2'd0;
   localparam logic [1:0] REG_WINDOW_LOG2 = 2'd1;
   localparam logic [1:0] REG_IMAGE_SIDE  = 2'd2;

   // Reset values of the registers
   localparam logic [1:0] POOL_MODE_RST   = MODE_MAX;
   localparam logic [1:0] WINDOW_LOG2_RST = 2'd1;
   localparam logic [8:0] IMAGE_SIDE_RST  = 9'd4;

   // Window position of one pixel, decoded from the raster counters
   typedef struct packed {
      logic       geom_ok;     // geometry usable, window may be pooled
      logic       first;       // top-left pixel of its window
      logic       last;        // bottom-right pixel of its window
      logic       frame_end;   // last pixel of the image
      logic [7:0] out_row;     // row in the output map
   } pos_type;

endpackage

@@ hdl/pixel_pooling_max_min_avg.sv @@
// Top level of the streaming 2D pooling block (maximum, minimum, average).
// Depends on ppool_pkg, ppool_raster and assert_macros.svh.
//
// Pixels of a square image enter on req_ in raster order, top left first, one
// beat each. Non-overlapping K by K windows (K = 1, 2, 4 or 8, stride K) are
// pooled; one beat leaves on rsp_ per finished window carrying the value and
// its output column and row, with rsp_tlast on the image's last window.
// Throughput: one pixel per clock while the output does not stall. Each pixel
// makes one read-modify-write of the per-column partial store; the read is
// issued as the beat is taken and the result written back as the input
// stage advances, with a bypass register covering back-to-back pixels of
// the same window. A window's result is held in the input stage, then
// loaded into the output register that drives rsp_.
// Stall: the finished result waits in the output register while the next
// pixels keep arriving; req_tready drops only when a second result is ready
// and the first has not yet been taken.
// Reset clears the counters and the pipeline and loads the registers with
// maximum mode, K = 2 and a 4 by 4 image. Any register write restarts the
// frame at the next pixel; write registers only while the block is idle.
// An unusable geometry takes and counts pixels but gives no results.
`include "assert_macros.svh"

module pixel_pooling_max_min_avg #(
   parameter int MAX_SIDE        = 256,
   parameter int MAX_WINDOW_LOG2 = 3
) (
   input  logic        clock,
   input  logic        reset,
   // pixel beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] pixel
   // pooled beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] pooled, [15:8] out_col, [23:16] out_row
   output logic        rsp_tlast,    // frame_done
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ppool_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);
   localparam int PW = 8 + 2 * MAX_WINDOW_LOG2;

   // configuration registers
   logic [1:0]    pool_mode_ff;
   logic [1:0]    window_log2_ff;
   logic [8:0]    image_side_ff;
   logic          csr_wr;
   logic [1:0]    csr_idx;
   logic          cfg_hit;

   // raster position of the next pixel
   logic [CW-1:0] cur_col;
   pos_type       cur_pos;

   // input stage
   logic          accept;
   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_pixel_ff;
   logic [CW-1:0] s1_oc_ff;
   pos_type       s1_pos_ff;
   logic [PW-1:0] rd_ff;
   logic          byp_hit_ff, byp_hit_in;
   logic [PW-1:0] byp_data_ff;
   logic          s1_emit;
   logic          s1_adv;
   logic          s1_wr;

   // combine stage
   logic [PW-1:0] cur_part;
   logic [PW-1:0] pix_ext;
   logic [PW-1:0] new_part;
   logic [PW-1:0] avg_val;
   logic [7:0]    pooled;

   // output register
   logic          rsp_valid_ff;
   logic [23:0]   rsp_data_ff;
   logic          rsp_last_ff;

   // line store of partial window results, one entry per output column
   logic [PW-1:0] line_mem [MAX_SIDE];

   // register writes on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];
   assign cfg_hit    = csr_wr && (csr_idx == REG_POOL_MODE || csr_idx == REG_WINDOW_LOG2
                                  || csr_idx == REG_IMAGE_SIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_mode_ff   <= POOL_MODE_RST;
         window_log2_ff <= WINDOW_LOG2_RST;
         image_side_ff  <= IMAGE_SIDE_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_POOL_MODE:   pool_mode_ff   <= csr_pwdata[1:0];
            REG_WINDOW_LOG2: window_log2_ff <= csr_pwdata[1:0];
            REG_IMAGE_SIDE:  image_side_ff  <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      unique case (csr_idx)
         REG_POOL_MODE:   csr_prdata = {30'd0, pool_mode_ff};
         REG_WINDOW_LOG2: csr_prdata = {30'd0, window_log2_ff};
         REG_IMAGE_SIDE:  csr_prdata = {23'd0, image_side_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   ppool_raster #(
      .MAX_SIDE        (MAX_SIDE),
      .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
   ) u_raster (
      .clock       (clock),
      .reset       (reset),
      .clear       (cfg_hit),
      .advance     (accept),
      .window_log2 (window_log2_ff),
      .image_side  (image_side_ff),
      .out_col     (cur_col),
      .pos         (cur_pos)
   );

   // handshake: the input stage moves on unless its result finds the output full
   assign s1_emit    = s1_valid_ff && s1_pos_ff.geom_ok && s1_pos_ff.last;
   assign s1_adv     = !s1_emit || !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign s1_wr      = s1_valid_ff && s1_pos_ff.geom_ok && s1_adv;

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   // forward the write going out at the same edge as this read
   assign byp_hit_in  = accept ? (s1_wr && (s1_oc_ff == cur_col))
                               : (s1_adv ? 1'b0 : byp_hit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         byp_hit_ff  <= byp_hit_in;
      end
   end

   // capture the beat and its position, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_tdata;
         s1_oc_ff    <= cur_col;
         s1_pos_ff   <= cur_pos;
         byp_data_ff <= new_part;
      end
   end

   // line store: write back the combined value, read for the incoming beat
   always_ff @(posedge clock) begin
      if (s1_wr) begin
         line_mem[s1_oc_ff] <= new_part;
      end
      if (accept) begin
         rd_ff <= line_mem[cur_col];
      end
   end

   // combine the pixel with the partial result of its window
   assign cur_part = byp_hit_ff ? byp_data_ff : rd_ff;
   assign pix_ext  = PW'(s1_pixel_ff);

   always_comb begin
      if (s1_pos_ff.first) begin
         new_part = pix_ext;
      end else begin
         unique case (pool_mode_ff)
            MODE_AVG: new_part = cur_part + pix_ext;
            MODE_MAX: new_part = (pix_ext > cur_part) ? pix_ext : cur_part;
            default:  new_part = (pix_ext < cur_part) ? pix_ext : cur_part;
         endcase
      end
   end

   // average truncates the full window sum by K*K
   assign avg_val = new_part >> {window_log2_ff, 1'b0};
   assign pooled  = (pool_mode_ff == MODE_AVG) ? avg_val[7:0] : new_part[7:0];

   // output register: load a finished window, drop the beat once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_emit && s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_emit && s1_adv) begin
         rsp_data_ff <= {s1_pos_ff.out_row, 8'(s1_oc_ff), pooled};
         rsp_last_ff <= s1_pos_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `ASSERT_CLK(a_byp_needs_item, clock, reset, byp_hit_ff |-> s1_valid_ff, "bypass set without an item in the input stage")
   `ASSERT_CLK(a_stall_holds_read, clock, reset, (s1_valid_ff && !s1_adv) |=> $stable(rd_ff), "store read data changed while the input stage stalled")
   `ASSERT_CLK(a_frame_end_square, clock, reset, (rsp_valid_ff && rsp_last_ff) |-> (rsp_data_ff[15:8] == rsp_data_ff[23:16]), "last window of the image is off the diagonal")

endmodule

@@ hdl/ppool_raster.sv @@
// Raster position counters and window decode for the pooling block.
// Depends on ppool_pkg.
module ppool_raster #(
   parameter int MAX_SIDE        = 256,
   parameter int MAX_WINDOW_LOG2 = 3,
   localparam int CW             = $clog2(MAX_SIDE)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                advance,
   input  logic [1:0]          window_log2,
   input  logic [8:0]          image_side,
   output logic [CW-1:0]       out_col,
   output ppool_pkg::pos_type  pos
);
   import ppool_pkg::*;

   localparam int SW = CW + 1;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic          side_bad;
   logic [SW-1:0] side_eff;
   logic [SW-1:0] side_m1;
   logic [SW-1:0] col_nxt;
   logic [SW-1:0] row_nxt;
   logic [8:0]    win_k;
   logic [CW-1:0] win_m;

   // Out-of-range side wraps the counters at the store depth
   assign side_bad = (image_side == 9'd0) || (32'(image_side) > MAX_SIDE);
   assign side_eff = side_bad ? SW'(MAX_SIDE) : SW'(image_side);
   assign side_m1  = side_eff - SW'(1);
   assign col_nxt  = {1'b0, col_ff} + SW'(1);
   assign row_nxt  = {1'b0, row_ff} + SW'(1);

   // Window side and in-window offset mask
   assign win_k = 9'd1 << window_log2;
   assign win_m = ~({CW{1'b1}} << window_log2);

   // Decode the current pixel's place in its window
   always_comb begin
      pos.geom_ok   = !side_bad && (32'(window_log2) <= MAX_WINDOW_LOG2)
                      && (win_k <= image_side)
                      && ((image_side & (win_k - 9'd1)) == 9'd0);
      pos.first     = ((col_ff & win_m) == '0) && ((row_ff & win_m) == '0);
      pos.last      = ((col_ff & win_m) == win_m) && ((row_ff & win_m) == win_m);
      pos.frame_end = ({1'b0, col_ff} == side_m1) && ({1'b0, row_ff} == side_m1);
      pos.out_row   = 8'(row_ff >> window_log2);
      out_col       = col_ff >> window_log2;
   end

   // Step through the raster, wrap at the end of a row and of the image
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (clear) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (col_nxt >= side_eff) begin
            col_in = '0;
            row_in = (row_nxt >= side_eff) ? '0 : row_nxt[CW-1:0];
         end else begin
            col_in = col_nxt[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule
